// ===== rtl/core/nfa_pkg.sv =====
// shared constants, types and codes for the feature accumulator core
`timescale 1ns / 1ps
package nfa_pkg;

  // network shape
  localparam int HALF_DIMS    = 256;
  localparam int FEATURES     = 1548;
  localparam int KING_SQUARES = 81;

  // item field widths
  localparam int FUNC_W = 3;
  localparam int KS_W   = 7;
  localparam int FEAT_W = 11;
  localparam int LANE_W = 8;
  localparam int VAL_W  = 16;

  // memory word organization: several lanes per word
  localparam int LANE_BITS = 16;
  localparam int LPW       = (HALF_DIMS < 16) ? HALF_DIMS : 16;
  localparam int LSEL_W    = $clog2(LPW);
  localparam int WORD_W    = LPW * LANE_BITS;
  localparam int WPR       = (HALF_DIMS + LPW - 1) / LPW;
  localparam int WPR_W     = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int LAST_LANES = HALF_DIMS - (WPR - 1) * LPW;

  // weight store addressing
  localparam int ROWS     = KING_SQUARES * FEATURES;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WT_WORDS = ROWS * WPR;
  localparam int WT_AW    = (WT_WORDS > 1) ? $clog2(WT_WORDS) : 1;

  // accumulator store: one word row block per perspective
  localparam int ACC_AW   = WPR_W + 1;
  localparam int ACC_ROWS = 2 ** ACC_AW;

  // transform output packing
  localparam int BYTES_PER_BEAT = 8;
  localparam int OUT_W          = BYTES_PER_BEAT * 8;
  localparam int RESULT_COUNT   = (2 * HALF_DIMS + BYTES_PER_BEAT - 1) / BYTES_PER_BEAT;
  localparam int RES_W          = $clog2(RESULT_COUNT);
  localparam int BUF_BYTES      = BYTES_PER_BEAT + LPW - 1;
  localparam int BCNT_W         = $clog2(BUF_BYTES + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LPW-1:0][7:0] lane_bytes_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_BIAS_WR   = 3'd0,
    FN_WEIGHT_WR = 3'd1,
    FN_LOAD_BIAS = 3'd2,
    FN_ADD_ROW   = 3'd3,
    FN_SUB_ROW   = 3'd4,
    FN_TRANSFORM = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ALU_PASS,
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    acc_ok;
  } alu_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BIAS_WR,
    S_ROW_IDX,
    S_ROW_BASE,
    S_WT_WR,
    S_ROW_OP,
    S_XF_RD,
    S_XF_CAT,
    S_XF_EMIT
  } state_t;

endpackage

// ===== rtl/core/nfa_lane_alu.sv =====
// shared lane unit: wrapping add, subtract or pass per lane, and 0..127 clamp
`timescale 1ns / 1ps
module nfa_lane_alu (
  input  nfa_pkg::alu_ctl_t    ctl,
  input  nfa_pkg::word_t       acc_word,
  input  nfa_pkg::word_t       operand,
  output nfa_pkg::word_t       result,
  output nfa_pkg::lane_bytes_t clamp_bytes
);

  always_comb begin
    logic [nfa_pkg::LANE_BITS-1:0] a;
    logic [nfa_pkg::LANE_BITS-1:0] b;
    logic [nfa_pkg::LANE_BITS-1:0] r;
    result      = '0;
    clamp_bytes = '0;
    for (int j = 0; j < nfa_pkg::LPW; j++) begin
      // never-loaded accumulator rows read as zero
      a = ctl.acc_ok ? acc_word[j*nfa_pkg::LANE_BITS +: nfa_pkg::LANE_BITS] : '0;
      b = operand[j*nfa_pkg::LANE_BITS +: nfa_pkg::LANE_BITS];
      unique case (ctl.op)
        nfa_pkg::ALU_PASS: r = b;
        nfa_pkg::ALU_ADD:  r = a + b;
        nfa_pkg::ALU_SUB:  r = a - b;
        default:           r = b;
      endcase
      result[j*nfa_pkg::LANE_BITS +: nfa_pkg::LANE_BITS] = r;
      // negative to 0, above 127 to 127
      if (a[nfa_pkg::LANE_BITS-1]) begin
        clamp_bytes[j] = 8'd0;
      end else if (|a[nfa_pkg::LANE_BITS-2:7]) begin
        clamp_bytes[j] = 8'd127;
      end else begin
        clamp_bytes[j] = {1'b0, a[6:0]};
      end
    end
  end

endmodule

// ===== rtl/core/nnue_feature_accumulator_core.sv =====
// feature accumulator core: bias/weight stores, two accumulators, transform packer
// steps: bias write S_BIAS_WR; weight write S_ROW_IDX, S_ROW_BASE, S_WT_WR; reload from
//   bias S_ROW_OP; row add or subtract S_ROW_IDX, S_ROW_BASE, S_ROW_OP; S_ROW_OP reads
//   one 16-lane word per cycle from the bias or weight store; transform: per accumulator
//   word S_XF_RD, S_XF_CAT, two beats in S_XF_EMIT (64 in all); EMIT holds while output stalls
// one item at a time: item_stall is high from acceptance until the item is finished
// reset (rst, synchronous): accumulators read as zero through per-row valid bits; bias and
//   weight stores keep their contents and must be written before use
`timescale 1ns / 1ps
module nnue_feature_accumulator_core (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [nfa_pkg::FUNC_W-1:0]    func,
  input  logic                          perspective,
  input  logic [nfa_pkg::KS_W-1:0]      king_square,
  input  logic [nfa_pkg::FEAT_W-1:0]    feature,
  input  logic [nfa_pkg::LANE_W-1:0]    lane,
  input  logic signed [nfa_pkg::VAL_W-1:0] value,
  input  logic                          side_to_move,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [nfa_pkg::OUT_W-1:0]     packed_bytes,
  output logic                          last
);

  // ------------------------------------------------------------------
  // sequencer state and captured item
  // ------------------------------------------------------------------
  nfa_pkg::state_t state, state_next;

  logic [nfa_pkg::FUNC_W-1:0] func_q;
  logic                       persp_q;
  logic [nfa_pkg::KS_W-1:0]   ks_q;
  logic [nfa_pkg::FEAT_W-1:0] feat_q;
  logic [nfa_pkg::LANE_W-1:0] lane_q;
  logic [nfa_pkg::VAL_W-1:0]  value_q;
  logic                       stm_q;

  logic item_accept;
  logic lane_ok;
  logic row_ok;

  assign item_accept = item_valid && !item_stall;
  assign lane_ok = int'(lane) < nfa_pkg::HALF_DIMS;
  assign row_ok  = (int'(king_square) < nfa_pkg::KING_SQUARES) &&
                   (int'(feature) < nfa_pkg::FEATURES);

  // lane split for single element writes
  logic [nfa_pkg::WPR_W-1:0]  lane_word;
  logic [nfa_pkg::LSEL_W-1:0] lane_sel;
  assign lane_word = nfa_pkg::WPR_W'(lane_q >> nfa_pkg::LSEL_W);
  assign lane_sel  = lane_q[nfa_pkg::LSEL_W-1:0];

  // weight row address, built in S_ROW_IDX then S_ROW_BASE (one constant multiply each)
  logic [nfa_pkg::ROW_W-1:0] row_idx;
  logic [nfa_pkg::WT_AW-1:0] row_base;

  // row sweep counters: read issue, then write-back in the next cycle
  logic [nfa_pkg::WPR_W-1:0] rd_idx;
  logic                      rd_more;
  logic                      pipe_v;
  logic [nfa_pkg::WPR_W-1:0] pipe_idx;
  logic                      rd_last;
  assign rd_last = rd_idx == nfa_pkg::WPR_W'(nfa_pkg::WPR - 1);

  // transform walk and byte gather buffer
  logic                       xf_half;
  logic [nfa_pkg::WPR_W-1:0]  xf_pos;
  logic                       xf_done;
  logic [nfa_pkg::BCNT_W-1:0] xf_n;
  logic [nfa_pkg::BCNT_W-1:0] xf_cnt;
  logic [nfa_pkg::BCNT_W-1:0] cat_cnt;
  logic [nfa_pkg::BCNT_W-1:0] emit_cnt;
  logic [nfa_pkg::RES_W-1:0]  res_cnt;
  logic [nfa_pkg::BUF_BYTES-1:0][7:0] xbuf;
  logic [nfa_pkg::BUF_BYTES-1:0][7:0] xbuf_cat;
  logic                       xf_persp;
  logic                       xf_pos_last;

  assign xf_persp    = xf_half ^ stm_q;
  assign xf_pos_last = xf_pos == nfa_pkg::WPR_W'(nfa_pkg::WPR - 1);
  assign cat_cnt     = xf_cnt + xf_n;
  assign emit_cnt    = (xf_cnt >= nfa_pkg::BCNT_W'(nfa_pkg::BYTES_PER_BEAT)) ?
                       xf_cnt - nfa_pkg::BCNT_W'(nfa_pkg::BYTES_PER_BEAT) : '0;

  // output register
  logic out_free;
  assign out_free = !result_valid || !result_stall;

  // datapath control from the sequencer
  logic rd_issue;
  logic acc_we;
  logic emit;
  logic bias_we;
  logic wt_we;

  // ------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      nfa_pkg::S_IDLE: begin
        if (item_accept) begin
          unique case (func)
            nfa_pkg::FN_BIAS_WR:   state_next = lane_ok ? nfa_pkg::S_BIAS_WR : nfa_pkg::S_IDLE;
            nfa_pkg::FN_WEIGHT_WR: state_next = (lane_ok && row_ok) ? nfa_pkg::S_ROW_IDX
                                                                    : nfa_pkg::S_IDLE;
            nfa_pkg::FN_LOAD_BIAS: state_next = nfa_pkg::S_ROW_OP;
            nfa_pkg::FN_ADD_ROW,
            nfa_pkg::FN_SUB_ROW:   state_next = row_ok ? nfa_pkg::S_ROW_IDX : nfa_pkg::S_IDLE;
            nfa_pkg::FN_TRANSFORM: state_next = nfa_pkg::S_XF_RD;
            default:               state_next = nfa_pkg::S_IDLE;
          endcase
        end
      end
      nfa_pkg::S_BIAS_WR:  state_next = nfa_pkg::S_IDLE;
      nfa_pkg::S_ROW_IDX:  state_next = nfa_pkg::S_ROW_BASE;
      nfa_pkg::S_ROW_BASE: state_next = (func_q == nfa_pkg::FN_WEIGHT_WR) ? nfa_pkg::S_WT_WR
                                                                           : nfa_pkg::S_ROW_OP;
      nfa_pkg::S_WT_WR:    state_next = nfa_pkg::S_IDLE;
      nfa_pkg::S_ROW_OP: begin
        if (pipe_v && pipe_idx == nfa_pkg::WPR_W'(nfa_pkg::WPR - 1)) begin
          state_next = nfa_pkg::S_IDLE;
        end
      end
      nfa_pkg::S_XF_RD:    state_next = nfa_pkg::S_XF_CAT;
      nfa_pkg::S_XF_CAT: begin
        if (cat_cnt >= nfa_pkg::BCNT_W'(nfa_pkg::BYTES_PER_BEAT) || xf_done) begin
          state_next = nfa_pkg::S_XF_EMIT;
        end else begin
          state_next = nfa_pkg::S_XF_RD;
        end
      end
      nfa_pkg::S_XF_EMIT: begin
        if (out_free) begin
          priority if (emit_cnt >= nfa_pkg::BCNT_W'(nfa_pkg::BYTES_PER_BEAT)) begin
            state_next = nfa_pkg::S_XF_EMIT;
          end else if (!xf_done) begin
            state_next = nfa_pkg::S_XF_RD;
          end else if (emit_cnt != '0) begin
            state_next = nfa_pkg::S_XF_EMIT;
          end else begin
            state_next = nfa_pkg::S_IDLE;
          end
        end
      end
      default: state_next = nfa_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // sequencer outputs
  // ------------------------------------------------------------------
  always_comb begin
    item_stall = 1'b1;
    rd_issue   = 1'b0;
    acc_we     = 1'b0;
    emit       = 1'b0;
    bias_we    = 1'b0;
    wt_we      = 1'b0;
    unique case (state)
      nfa_pkg::S_IDLE:    item_stall = 1'b0;
      nfa_pkg::S_BIAS_WR: bias_we = 1'b1;
      nfa_pkg::S_WT_WR:   wt_we = 1'b1;
      nfa_pkg::S_ROW_OP: begin
        rd_issue = rd_more;
        acc_we   = pipe_v;
      end
      nfa_pkg::S_XF_EMIT: emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the item at acceptance
  always_ff @(posedge clk) begin
    if (item_accept) begin
      func_q  <= func;
      persp_q <= perspective;
      ks_q    <= king_square;
      feat_q  <= feature;
      lane_q  <= lane;
      value_q <= value;
      stm_q   <= side_to_move;
    end
  end

  always_ff @(posedge clk) begin
    if (state == nfa_pkg::S_ROW_IDX) begin
      row_idx <= nfa_pkg::ROW_W'(nfa_pkg::ROW_W'(ks_q) * nfa_pkg::ROW_W'(nfa_pkg::FEATURES)) +
                 nfa_pkg::ROW_W'(feat_q);
    end
    if (state == nfa_pkg::S_ROW_BASE) begin
      row_base <= nfa_pkg::WT_AW'(nfa_pkg::WT_AW'(row_idx) * nfa_pkg::WT_AW'(nfa_pkg::WPR));
    end
  end

  // row sweep: counters rest at zero outside the sweep
  always_ff @(posedge clk) begin
    if (rst || state != nfa_pkg::S_ROW_OP) begin
      rd_idx  <= '0;
      rd_more <= 1'b1;
      pipe_v  <= 1'b0;
    end else begin
      pipe_v <= rd_issue;
      if (rd_issue) begin
        if (rd_last) begin
          rd_more <= 1'b0;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      pipe_idx <= rd_idx;
    end
  end

  // ------------------------------------------------------------------
  // memories
  // ------------------------------------------------------------------
  nfa_pkg::word_t weight_mem [nfa_pkg::WT_WORDS];
  nfa_pkg::word_t bias_mem [nfa_pkg::WPR];
  nfa_pkg::word_t acc_mem [nfa_pkg::ACC_ROWS];
  logic [nfa_pkg::ACC_ROWS-1:0] acc_valid;

  nfa_pkg::word_t wt_rd;
  nfa_pkg::word_t bias_rd;
  nfa_pkg::word_t acc_rd;
  logic           acc_ok;

  logic [nfa_pkg::WT_AW-1:0]  wt_addr;
  logic [nfa_pkg::ACC_AW-1:0] acc_raddr;
  logic [nfa_pkg::ACC_AW-1:0] acc_waddr;
  nfa_pkg::word_t             alu_result;
  nfa_pkg::lane_bytes_t       lane_bytes;

  assign wt_addr = wt_we ? row_base + nfa_pkg::WT_AW'(lane_word)
                         : row_base + nfa_pkg::WT_AW'(rd_idx);
  assign acc_raddr = (state == nfa_pkg::S_XF_RD) ? {xf_persp, xf_pos} : {persp_q, rd_idx};
  assign acc_waddr = {persp_q, pipe_idx};

  // weight store: single lane writes, one word read per cycle
  always_ff @(posedge clk) begin
    if (wt_we) begin
      weight_mem[wt_addr][lane_sel*nfa_pkg::LANE_BITS +: nfa_pkg::LANE_BITS] <= value_q;
    end
    wt_rd <= weight_mem[wt_addr];
  end

  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_mem[lane_word][lane_sel*nfa_pkg::LANE_BITS +: nfa_pkg::LANE_BITS] <= value_q;
    end
    bias_rd <= bias_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= alu_result;
    end
    acc_rd <= acc_mem[acc_raddr];
  end

  // per-row valid bits stand in for clearing the accumulators at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
      acc_ok    <= 1'b0;
    end else begin
      if (acc_we) begin
        acc_valid[acc_waddr] <= 1'b1;
      end
      acc_ok <= acc_valid[acc_raddr];
    end
  end

  // ------------------------------------------------------------------
  // shared lane unit
  // ------------------------------------------------------------------
  nfa_pkg::alu_ctl_t alu_ctl;
  nfa_pkg::word_t    alu_operand;

  always_comb begin
    alu_ctl.acc_ok = acc_ok;
    unique case (func_q)
      nfa_pkg::FN_ADD_ROW: alu_ctl.op = nfa_pkg::ALU_ADD;
      nfa_pkg::FN_SUB_ROW: alu_ctl.op = nfa_pkg::ALU_SUB;
      default:             alu_ctl.op = nfa_pkg::ALU_PASS;
    endcase
    alu_operand = (func_q == nfa_pkg::FN_LOAD_BIAS) ? bias_rd : wt_rd;
  end

  nfa_lane_alu u_alu (
    .ctl         (alu_ctl),
    .acc_word    (acc_rd),
    .operand     (alu_operand),
    .result      (alu_result),
    .clamp_bytes (lane_bytes)
  );

  // ------------------------------------------------------------------
  // transform: walk side-to-move rows then the other side, gather bytes
  // ------------------------------------------------------------------
  always_comb begin
    xbuf_cat = xbuf;
    for (int i = 0; i < nfa_pkg::BUF_BYTES; i++) begin
      if (i >= int'(xf_cnt) && i < int'(xf_cnt) + int'(xf_n)) begin
        xbuf_cat[i] = lane_bytes[nfa_pkg::LSEL_W'(i - int'(xf_cnt))];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state == nfa_pkg::S_IDLE) begin
      xf_half <= 1'b0;
      xf_pos  <= '0;
      xf_done <= 1'b0;
      xf_cnt  <= '0;
      res_cnt <= '0;
      xbuf    <= '0;
    end else begin
      if (state == nfa_pkg::S_XF_RD) begin
        // last word of a half carries LAST_LANES lanes (a full word with the present shape)
        xf_n <= xf_pos_last ? nfa_pkg::BCNT_W'(nfa_pkg::LAST_LANES)
                            : nfa_pkg::BCNT_W'(nfa_pkg::LPW);
        if (xf_pos_last) begin
          xf_pos <= '0;
          if (xf_half) begin
            xf_done <= 1'b1;
          end else begin
            xf_half <= 1'b1;
          end
        end else begin
          xf_pos <= xf_pos + 1'b1;
        end
      end
      if (state == nfa_pkg::S_XF_CAT) begin
        xbuf   <= xbuf_cat;
        xf_cnt <= cat_cnt;
      end
      if (emit) begin
        xbuf    <= xbuf >> nfa_pkg::OUT_W;
        xf_cnt  <= emit_cnt;
        res_cnt <= res_cnt + 1'b1;
      end
    end
  end

  // output register parts the result channel from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      packed_bytes <= xbuf[nfa_pkg::BYTES_PER_BEAT-1:0];
      last         <= res_cnt == nfa_pkg::RES_W'(nfa_pkg::RESULT_COUNT - 1);
    end
  end

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  // the final beat of a transform leaves nothing behind
  a_last_ends_xf: assert property (@(posedge clk) disable iff (rst)
    emit && res_cnt == nfa_pkg::RES_W'(nfa_pkg::RESULT_COUNT - 1) |=> state == nfa_pkg::S_IDLE)
    else $error("transform did not finish on its last beat");

  // a beat is only sent with bytes in the gather buffer
  a_emit_has_bytes: assert property (@(posedge clk) disable iff (rst)
    state == nfa_pkg::S_XF_EMIT |-> xf_cnt != '0)
    else $error("emit state with empty gather buffer");

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    xf_cnt <= nfa_pkg::BCNT_W'(nfa_pkg::BUF_BYTES))
    else $error("gather buffer overflow");

  // write-back never lands on the word being read in the same cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    acc_we && rd_issue |-> pipe_idx != rd_idx)
    else $error("accumulator read and write-back collide");

endmodule

// ===== bench/tb_nnue_feature_accumulator_core.sv =====
// self-checking bench for the feature accumulator core: mirrored stores, beat-by-beat check
`timescale 1ns / 1ps
module tb_nnue_feature_accumulator_core;
  import nfa_pkg::*;

  // function codes the block leaves unused
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 370;
  localparam int LONG_HOLD    = 400;   // one long receiver hold-off, in cycles
  localparam int HOLD_AFTER   = 300;   // beats taken before the long hold starts
  localparam int SETTLE       = 64;    // cycles of quiet at the end
  localparam int KS_MAX       = (1 << KS_W) - 1;
  localparam int FEAT_MAX     = (1 << FEAT_W) - 1;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic              persp;
    logic [KS_W-1:0]   ks;
    logic [FEAT_W-1:0] feat;
    logic [LANE_W-1:0] ln;
    logic [VAL_W-1:0]  val;
    logic              stm;
    int                gap;     // idle cycles before this item is offered
    bit                drain;   // hold the item back until every owed beat has arrived
  } item_t;

  typedef struct {
    logic [OUT_W-1:0] bytes;
    logic             last;
  } beat_t;

  // clock and reset
  logic clk;
  logic rst = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // item channel, held at known values from time zero
  logic              item_valid   = 1'b0;
  logic              item_stall;
  logic [FUNC_W-1:0] func         = '0;
  logic              perspective  = 1'b0;
  logic [KS_W-1:0]   king_square  = '0;
  logic [FEAT_W-1:0] feature      = '0;
  logic [LANE_W-1:0] lane         = '0;
  logic [VAL_W-1:0]  value        = '0;
  logic              side_to_move = 1'b0;

  // result channel
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [OUT_W-1:0]  packed_bytes;
  logic              last;

  nnue_feature_accumulator_core dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .func        (func),
    .perspective (perspective),
    .king_square (king_square),
    .feature     (feature),
    .lane        (lane),
    .value       (value),
    .side_to_move(side_to_move),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .packed_bytes(packed_bytes),
    .last        (last)
  );

  // mirror of the block state; weights only where written
  logic [VAL_W-1:0] acc_mirror [2][HALF_DIMS];
  logic [VAL_W-1:0] bias_mirror [HALF_DIMS];
  logic [VAL_W-1:0] weight_mirror [int];

  item_t pending [$];     // items still to be offered
  beat_t owed_beats [$];  // transform beats predicted but not yet seen
  int    row_ks [$];      // rows whose every lane has been written
  int    row_feat [$];

  int beats_owed  = 0;    // driver side, blocking
  int beats_taken = 0;    // monitor side, nonblocking
  int errors      = 0;
  int n_items = 0, n_add = 0, n_sub = 0, n_xf = 0;
  bit calm = 1'b0;        // stimulus stretch with no sender gaps

  // ---------------------------------------------------------------- prediction

  function automatic logic [7:0] clamp_byte(input logic [VAL_W-1:0] raw);
    if (raw[VAL_W-1]) return 8'd0;
    if (raw > 16'd127) return 8'd127;
    return raw[7:0];
  endfunction

  task automatic mirror_item(input item_t it);
    int    row;
    int    j;
    int    k;
    int    b;
    int    idx;
    bit    row_ok;
    logic  p;
    logic [VAL_W-1:0] w;
    beat_t bt;
    row    = int'(it.ks) * FEATURES + int'(it.feat);
    row_ok = int'(it.ks) < KING_SQUARES && int'(it.feat) < FEATURES;
    n_items++;
    case (it.fn)
      FN_BIAS_WR: begin
        if (int'(it.ln) < HALF_DIMS) bias_mirror[it.ln] = it.val;
      end
      FN_WEIGHT_WR: begin
        if (row_ok && int'(it.ln) < HALF_DIMS) weight_mirror[row * HALF_DIMS + int'(it.ln)] = it.val;
      end
      FN_LOAD_BIAS: begin
        for (j = 0; j < HALF_DIMS; j++) acc_mirror[it.persp][j] = bias_mirror[j];
      end
      FN_ADD_ROW, FN_SUB_ROW: begin
        if (it.fn == FN_ADD_ROW) n_add++;
        else n_sub++;
        // the no-feature marker and anything out of range leave the accumulator alone
        if (row_ok) begin
          for (j = 0; j < HALF_DIMS; j++) begin
            w = weight_mirror.exists(row * HALF_DIMS + j) ? weight_mirror[row * HALF_DIMS + j] : '0;
            if (it.fn == FN_ADD_ROW) acc_mirror[it.persp][j] = acc_mirror[it.persp][j] + w;
            else acc_mirror[it.persp][j] = acc_mirror[it.persp][j] - w;
          end
        end
      end
      FN_TRANSFORM: begin
        n_xf++;
        // side to move first, then the other view; eight clamped lanes per beat
        for (k = 0; k < RESULT_COUNT; k++) begin
          bt.bytes = '0;
          for (b = 0; b < BYTES_PER_BEAT; b++) begin
            idx = k * BYTES_PER_BEAT + b;
            if (idx < 2 * HALF_DIMS) begin
              p = (idx < HALF_DIMS) ? it.stm : !it.stm;
              bt.bytes[8*b +: 8] = clamp_byte(acc_mirror[p][idx % HALF_DIMS]);
            end
          end
          bt.last = (k == RESULT_COUNT - 1);
          owed_beats.push_back(bt);
          beats_owed++;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  // also flips the no-gap stretch now and then
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 39) == 0) calm = !calm;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] small_val(input int lo, input int hi);
    int v;
    v = int'($urandom_range(0, hi - lo)) + lo;
    return v[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] wide_val();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'h7fff;
    if (r < 10) return 16'h8000;
    return $urandom;
  endfunction

  // every field but drain random; callers pin what matters
  function automatic item_t rand_item(input logic [FUNC_W-1:0] fn);
    item_t it;
    it.fn    = fn;
    it.persp = $urandom;
    it.ks    = $urandom;
    it.feat  = $urandom;
    it.ln    = $urandom;
    it.val   = $urandom;
    it.stm   = $urandom;
    it.gap   = pick_gap();
    it.drain = 1'b0;
    return it;
  endfunction

  // mostly fully written rows, the rest out of range or the no-feature marker
  function automatic item_t row_item(input logic [FUNC_W-1:0] fn);
    item_t it;
    int    r;
    int    k;
    it = rand_item(fn);
    r  = $urandom_range(0, 99);
    k  = $urandom_range(0, row_ks.size() - 1);
    if (r < 85) begin
      it.ks   = KS_W'(row_ks[k]);
      it.feat = FEAT_W'(row_feat[k]);
    end else if (r < 90) begin
      it.ks = KS_W'($urandom_range(KING_SQUARES, KS_MAX));
    end else if (r < 95) begin
      it.ks   = KS_W'($urandom_range(0, KING_SQUARES - 1));
      it.feat = FEAT_W'(FEATURES);
    end else begin
      it.ks   = KS_W'($urandom_range(0, KING_SQUARES - 1));
      it.feat = FEAT_W'($urandom_range(FEATURES + 1, FEAT_MAX));
    end
    return it;
  endfunction

  // fill every lane of a weight row so adds and subtracts never read an unwritten entry
  task automatic write_row(input int ks, input int feat, input bit wide);
    item_t it;
    int    j;
    for (j = 0; j < HALF_DIMS; j++) begin
      it      = rand_item(FN_WEIGHT_WR);
      it.ks   = KS_W'(ks);
      it.feat = FEAT_W'(feat);
      it.ln   = LANE_W'(j);
      if (!wide) it.val = small_val(-48, 48);
      else if (j == 0) it.val = 16'h7fff;
      else if (j == 1) it.val = 16'h8000;
      else it.val = wide_val();
      pending.push_back(it);
    end
    row_ks.push_back(ks);
    row_feat.push_back(feat);
  endtask

  task automatic queue_row_op(input logic [FUNC_W-1:0] fn, input logic persp, input int k);
    item_t it;
    it       = rand_item(fn);
    it.persp = persp;
    it.ks    = KS_W'(row_ks[k]);
    it.feat  = FEAT_W'(row_feat[k]);
    pending.push_back(it);
  endtask

  task automatic queue_plain(input logic [FUNC_W-1:0] fn, input logic persp, input logic stm,
                             input bit drain);
    item_t it;
    it       = rand_item(fn);
    it.persp = persp;
    it.stm   = stm;
    it.drain = drain;
    pending.push_back(it);
  endtask

  task automatic queue_odd_row(input logic [FUNC_W-1:0] fn, input int ks, input int feat);
    item_t it;
    it      = rand_item(fn);
    it.ks   = KS_W'(ks);
    it.feat = FEAT_W'(feat);
    pending.push_back(it);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what, input logic [OUT_W-1:0] want_v,
                               input logic [OUT_W-1:0] got_v);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s at beat %0d: expected %h, got %h", what, beats_taken, want_v, got_v);
  endtask

  // ---------------------------------------------------------------- item driver

  item_t cur_item;
  int    gap_left;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (item_valid && !item_stall) mirror_item(cur_item);
      // a new item may go out once the current one is taken or none is up
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (pending.size() > 0 && (!pending[0].drain || beats_taken >= beats_owed)) begin
          cur_item     = pending.pop_front();
          func         <= cur_item.fn;
          perspective  <= cur_item.persp;
          king_square  <= cur_item.ks;
          feature      <= cur_item.feat;
          lane         <= cur_item.ln;
          value        <= cur_item.val;
          side_to_move <= cur_item.stm;
          item_valid   <= 1'b1;
          gap_left     <= (pending.size() > 0) ? pending[0].gap : 0;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result monitor

  beat_t want;
  int    hold_left;
  int    calm_left;
  int    rx_roll;
  bit    rx_calm;
  bit    long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
      calm_left    <= 100;
      rx_calm      <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        beats_taken <= beats_taken + 1;
        if (owed_beats.size() == 0) begin
          flag_mismatch("beat with nothing owed", '0, packed_bytes);
        end else begin
          want = owed_beats.pop_front();
          if (packed_bytes !== want.bytes) flag_mismatch("packed_bytes", want.bytes, packed_bytes);
          if (last !== want.last) flag_mismatch("last", OUT_W'(want.last), OUT_W'(last));
        end
      end
      // stall pattern: one long hold-off mid-transform, short and long bursts, calm stretches
      rx_roll = $urandom_range(0, 99);
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        result_stall <= 1'b1;
      end else if (!long_hold_done && beats_taken >= HOLD_AFTER) begin
        long_hold_done <= 1'b1;
        hold_left      <= LONG_HOLD - 1;
        result_stall   <= 1'b1;
      end else if (rx_calm || rx_roll < 70) begin
        result_stall <= 1'b0;
      end else if (rx_roll < 96) begin
        hold_left    <= $urandom_range(0, 2);
        result_stall <= 1'b1;
      end else begin
        hold_left    <= $urandom_range(9, 39);
        result_stall <= 1'b1;
      end
      if (calm_left == 0) begin
        rx_calm   <= !rx_calm;
        calm_left <= $urandom_range(50, 300);
      end else begin
        calm_left <= calm_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus and end of run

  initial begin
    item_t it;
    int    n;
    int    r;
    int    j;
    bit    after_xf;

    // accumulators read zero out of reset
    queue_plain(FN_TRANSFORM, 1'b0, 1'b0, 1'b0);

    // whole bias vector, boundary values first
    for (j = 0; j < HALF_DIMS; j++) begin
      it    = rand_item(FN_BIAS_WR);
      it.ln = LANE_W'(j);
      case (j)
        0: it.val = 16'h7fff;
        1: it.val = 16'h8000;
        2: it.val = 16'd127;
        3: it.val = 16'd128;
        4: it.val = 16'd0;
        5: it.val = 16'hffff;
        default: it.val = ($urandom_range(0, 7) == 0) ? wide_val() : small_val(-40, 160);
      endcase
      pending.push_back(it);
    end

    // directed: reload, ignored rows, marker, spare codes
    queue_plain(FN_LOAD_BIAS, 1'b0, 1'b0, 1'b0);
    queue_plain(FN_TRANSFORM, 1'b0, 1'b1, 1'b0);
    queue_odd_row(FN_ADD_ROW, KS_MAX, 0);
    queue_odd_row(FN_ADD_ROW, 0, FEATURES);
    queue_odd_row(FN_SUB_ROW, KING_SQUARES - 1, FEAT_MAX);
    queue_odd_row(FN_SUB_ROW, KING_SQUARES, FEATURES - 1);
    queue_odd_row(FN_WEIGHT_WR, KING_SQUARES, 0);
    queue_odd_row(FN_WEIGHT_WR, 0, FEATURES);
    queue_odd_row(FN_WEIGHT_WR, KS_MAX, FEAT_MAX);
    queue_plain(FN_SPARE_6, 1'b1, 1'b1, 1'b0);
    queue_plain(FN_SPARE_7, 1'b0, 1'b0, 1'b0);

    // three full rows: corner rows and one in the middle
    write_row(0, 0, 1'b1);
    write_row(KING_SQUARES - 1, FEATURES - 1, 1'b0);
    write_row($urandom_range(1, KING_SQUARES - 2), $urandom_range(1, FEATURES - 2), 1'b0);

    // directed: wrapping adds, subtracts on both views, transforms both ways
    queue_plain(FN_LOAD_BIAS, 1'b1, 1'b0, 1'b0);
    queue_row_op(FN_ADD_ROW, 1'b0, 0);
    queue_row_op(FN_ADD_ROW, 1'b0, 0);
    queue_row_op(FN_ADD_ROW, 1'b1, 1);
    queue_row_op(FN_SUB_ROW, 1'b1, 2);
    queue_row_op(FN_SUB_ROW, 1'b0, 0);
    queue_row_op(FN_ADD_ROW, 1'b0, 0);
    queue_odd_row(FN_ADD_ROW, row_ks[1], FEATURES);
    queue_plain(FN_TRANSFORM, 1'b1, 1'b0, 1'b0);
    queue_plain(FN_TRANSFORM, 1'b0, 1'b1, 1'b1);
    queue_plain(FN_LOAD_BIAS, 1'b0, 1'b0, 1'b1);

    // random mix, row updates most common (mostly on written rows), with transforms in between
    after_xf = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 28) begin
        it = row_item(FN_ADD_ROW);
      end else if (r < 48) begin
        it = row_item(FN_SUB_ROW);
      end else if (r < 56) begin
        it = rand_item(FN_LOAD_BIAS);
      end else if (r < 66) begin
        it = rand_item(FN_TRANSFORM);
      end else if (r < 80) begin
        it     = row_item(FN_WEIGHT_WR);
        it.val = ($urandom_range(0, 3) == 0) ? wide_val() : small_val(-48, 48);
      end else if (r < 92) begin
        it     = rand_item(FN_BIAS_WR);
        it.val = ($urandom_range(0, 5) == 0) ? wide_val() : small_val(-40, 160);
      end else begin
        it = rand_item($urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7);
      end
      // sometimes let everything drain after a transform
      it.drain = after_xf && ($urandom_range(0, 3) == 0);
      after_xf = (it.fn == FN_TRANSFORM);
      pending.push_back(it);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || item_valid) @(posedge clk);
    while (beats_taken < beats_owed) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d items: %0d row adds, %0d row subtracts, %0d transforms",
             n_items, n_add, n_sub, n_xf);
    $display("%0d output beats checked, %0d mismatches", beats_taken, errors);
    if (errors == 0) begin
      $display("PASS nnue_feature_accumulator_core");
    end else begin
      $display("FAIL nnue_feature_accumulator_core");
    end
    $finish;
  end

  // hang guard
  initial begin
    #1200000;
    $display("timeout with %0d beats still owed", beats_owed - beats_taken);
    $display("FAIL nnue_feature_accumulator_core");
    $finish;
  end

endmodule
